// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the facet canonicalizer RTL.
// Needs signals named clk and rst in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cfc_pkg.sv =====
// Shared types, constants and facet tables of the facet canonicalizer.
// No dependencies; used by every other RTL file but assert_macros.svh.
package cfc_pkg;

  localparam int INDEX_BITS  = 32;
  localparam int KIND_W      = 2;
  localparam int IDX_W       = 32;
  localparam int VERT_W      = 31;
  localparam int FACE_W      = 32;
  localparam int FNUM_W      = 3;
  localparam int SLOT_W      = 3;
  localparam int NUM_VERTS   = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // source_index keeps the low INDEX_BITS bits of the cell index
  localparam logic [IDX_W-1:0] SRC_MASK =
    (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

  localparam logic [KIND_W-1:0] KIND_TET   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PYR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WEDGE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_HEX   = 2'd3;

  typedef enum logic [1:0] {
    OP_DEGEN = 2'd0,
    OP_TRI   = 2'd1,
    OP_QUAD  = 2'd2
  } facet_op_t;

  typedef struct packed {
    logic                   quad;
    logic [3:0][SLOT_W-1:0] slot;
  } facet_slots_t;

  typedef struct packed {
    facet_op_t              op;
    logic [3:0][VERT_W-1:0] v;
    logic [KIND_W-1:0]      kind;
    logic [FNUM_W-1:0]      fnum;
    logic [IDX_W-1:0]       index;
    logic                   last;
  } facet_job_t;

  function automatic facet_slots_t mk_slots(input logic q, input logic [SLOT_W-1:0] a,
                                            input logic [SLOT_W-1:0] b,
                                            input logic [SLOT_W-1:0] c,
                                            input logic [SLOT_W-1:0] d);
    facet_slots_t r;
    r.quad    = q;
    r.slot[0] = a;
    r.slot[1] = b;
    r.slot[2] = c;
    r.slot[3] = d;
    return r;
  endfunction

  function automatic logic [FNUM_W-1:0] facet_count(input logic [KIND_W-1:0] kind);
    logic [FNUM_W-1:0] n;
    case (kind)
      KIND_TET:   n = 3'd4;
      KIND_PYR:   n = 3'd5;
      KIND_WEDGE: n = 3'd5;
      default:    n = 3'd6;
    endcase
    return n;
  endfunction

  // Vertex slots of each facet; triangles leave the fourth slot unused.
  function automatic facet_slots_t facet_slots(input logic [KIND_W-1:0] kind,
                                               input logic [FNUM_W-1:0] fnum);
    facet_slots_t r;
    r = mk_slots(1'b0, 3'd0, 3'd0, 3'd0, 3'd0);
    case (kind)
      KIND_TET: begin
        case (fnum)
          3'd0:    r = mk_slots(1'b0, 3'd1, 3'd3, 3'd2, 3'd0);
          3'd1:    r = mk_slots(1'b0, 3'd0, 3'd2, 3'd3, 3'd0);
          3'd2:    r = mk_slots(1'b0, 3'd0, 3'd3, 3'd1, 3'd0);
          default: r = mk_slots(1'b0, 3'd0, 3'd1, 3'd2, 3'd0);
        endcase
      end
      KIND_PYR: begin
        case (fnum)
          3'd0:    r = mk_slots(1'b0, 3'd4, 3'd1, 3'd0, 3'd0);
          3'd1:    r = mk_slots(1'b0, 3'd4, 3'd2, 3'd1, 3'd0);
          3'd2:    r = mk_slots(1'b0, 3'd4, 3'd3, 3'd2, 3'd0);
          3'd3:    r = mk_slots(1'b0, 3'd4, 3'd0, 3'd3, 3'd0);
          default: r = mk_slots(1'b1, 3'd0, 3'd1, 3'd2, 3'd3);
        endcase
      end
      KIND_WEDGE: begin
        case (fnum)
          3'd0:    r = mk_slots(1'b0, 3'd0, 3'd2, 3'd1, 3'd0);
          3'd1:    r = mk_slots(1'b0, 3'd3, 3'd4, 3'd5, 3'd0);
          3'd2:    r = mk_slots(1'b1, 3'd0, 3'd3, 3'd5, 3'd2);
          3'd3:    r = mk_slots(1'b1, 3'd1, 3'd2, 3'd5, 3'd4);
          default: r = mk_slots(1'b1, 3'd0, 3'd1, 3'd4, 3'd3);
        endcase
      end
      default: begin
        case (fnum)
          3'd0:    r = mk_slots(1'b1, 3'd0, 3'd1, 3'd2, 3'd3);
          3'd1:    r = mk_slots(1'b1, 3'd4, 3'd7, 3'd6, 3'd5);
          3'd2:    r = mk_slots(1'b1, 3'd0, 3'd4, 3'd5, 3'd1);
          3'd3:    r = mk_slots(1'b1, 3'd2, 3'd6, 3'd7, 3'd3);
          3'd4:    r = mk_slots(1'b1, 3'd1, 3'd5, 3'd6, 3'd2);
          default: r = mk_slots(1'b1, 3'd0, 3'd3, 3'd7, 3'd4);
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/cfc_if.sv =====
// Valid/ready channel interfaces: cells in, facets out.
// Depends on cfc_pkg for field widths.
interface cfc_cell_if;
  logic                       valid;
  logic                       ready;
  logic [cfc_pkg::KIND_W-1:0] cell_kind;
  logic [cfc_pkg::IDX_W-1:0]  cell_index;
  logic [cfc_pkg::VERT_W-1:0] vert_a;
  logic [cfc_pkg::VERT_W-1:0] vert_b;
  logic [cfc_pkg::VERT_W-1:0] vert_c;
  logic [cfc_pkg::VERT_W-1:0] vert_d;
  logic [cfc_pkg::VERT_W-1:0] vert_e;
  logic [cfc_pkg::VERT_W-1:0] vert_f;
  logic [cfc_pkg::VERT_W-1:0] vert_g;
  logic [cfc_pkg::VERT_W-1:0] vert_h;

  modport source (output valid, cell_kind, cell_index, vert_a, vert_b, vert_c, vert_d,
                  vert_e, vert_f, vert_g, vert_h, input ready);
  modport sink   (input valid, cell_kind, cell_index, vert_a, vert_b, vert_c, vert_d,
                  vert_e, vert_f, vert_g, vert_h, output ready);
endinterface

interface cfc_face_if;
  logic                              valid;
  logic                              ready;
  logic signed [cfc_pkg::FACE_W-1:0] face_v0;
  logic signed [cfc_pkg::FACE_W-1:0] face_v1;
  logic signed [cfc_pkg::FACE_W-1:0] face_v2;
  logic signed [cfc_pkg::FACE_W-1:0] face_v3;
  logic [cfc_pkg::KIND_W-1:0]        source_kind;
  logic [cfc_pkg::FNUM_W-1:0]        facet_number;
  logic [cfc_pkg::IDX_W-1:0]         source_index;
  logic                              flipped;
  logic                              degenerate;
  logic                              last_facet;

  modport source (output valid, face_v0, face_v1, face_v2, face_v3, source_kind,
                  facet_number, source_index, flipped, degenerate, last_facet,
                  input ready);
  modport sink   (input valid, face_v0, face_v1, face_v2, face_v3, source_kind,
                  facet_number, source_index, flipped, degenerate, last_facet,
                  output ready);
endinterface

// ===== rtl/cell_facet_canonicalizer.sv =====
// Top level of the cell facet canonicalizer: front end, job queue, back end.
// Depends on cfc_pkg, cfc_if, cfc_front, cfc_queue and cfc_back.
//
// One cell beat (tetrahedron, pyramid, wedge or hexahedron) yields one facet
// beat per face: 4 for a tetrahedron, 5 for a pyramid or wedge, 6 for a
// hexahedron, in the fixed per-kind vertex order, the final one marked with
// last_facet. The single facet output channel moves one beat a cycle while
// facets.ready is high. The front end takes the next cell in the same
// cycle that the current cell's last facet enters the queue, so cells stream
// without gaps. A cell's first facet passes the cell register, a queue entry
// and then the output register before it is presented. Each facet is
// canonicalized: triangles sorted ascending, quads rotated to their smallest
// vertex with the second and fourth ordered, quads with one repeat reduced to
// a sorted triangle, and anything with fewer than three distinct vertices
// reported as all -1 with degenerate set. flipped carries the parity of the
// reorder swaps. Either side may stall freely; a two-entry queue decouples
// the front end's facet walk from the back end's output register.

module cell_facet_canonicalizer (
  input  logic        clk,
  input  logic        rst,
  cfc_cell_if.sink    cells,
  cfc_face_if.source  facets
);

  // front -> queue
  logic                f_valid;
  logic                f_ready;
  cfc_pkg::facet_job_t f_job;

  // queue -> back
  logic                b_valid;
  logic                b_ready;
  cfc_pkg::facet_job_t b_job;

  // Cell walk: gathers each facet's vertices and classifies it
  // (degenerate / triangle / quad) from the vertex equalities.
  cfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cells     (cells),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  cfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_job    (b_job)
  );

  // Ordering of vertices plus orientation parity, into the output register.
  cfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .facets    (facets)
  );

endmodule

// ===== rtl/cfc_front.sv =====
// Front end: holds one cell, walks its facets, gathers and classifies vertices.
// Depends on cfc_pkg, cfc_if and assert_macros.svh.
`include "assert_macros.svh"

module cfc_front (
  input  logic                clk,
  input  logic                rst,
  cfc_cell_if.sink            cells,
  output logic                job_valid,
  input  logic                job_ready,
  output cfc_pkg::facet_job_t job
);

  logic                                          busy;
  logic [cfc_pkg::KIND_W-1:0]                    kind;
  logic [cfc_pkg::IDX_W-1:0]                     index;
  logic [cfc_pkg::NUM_VERTS-1:0][cfc_pkg::VERT_W-1:0] verts;
  logic [cfc_pkg::FNUM_W-1:0]                    fcnt;

  cfc_pkg::facet_slots_t                         sl;
  logic [3:0][cfc_pkg::VERT_W-1:0]               v;
  logic e01, e02, e03, e12, e13, e23;
  logic new1, new2, new3;
  logic last, push, accept;

  assign sl = cfc_pkg::facet_slots(kind, fcnt);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      v[i] = verts[sl.slot[i]];
    end
  end

  assign e01 = (v[0] == v[1]);
  assign e02 = (v[0] == v[2]);
  assign e03 = (v[0] == v[3]);
  assign e12 = (v[1] == v[2]);
  assign e13 = (v[1] == v[3]);
  assign e23 = (v[2] == v[3]);

  // vertex i is new when it matches none before it
  assign new1 = !e01;
  assign new2 = !(e02 || e12);
  assign new3 = !(e03 || e13 || e23);

  assign last   = (fcnt == cfc_pkg::facet_count(kind) - 3'd1);
  assign push   = busy && job_ready;
  assign accept = cells.valid && cells.ready;

  assign cells.ready = !busy || (push && last);
  assign job_valid   = busy;

  always_comb begin
    job.kind  = kind;
    job.fnum  = fcnt;
    job.index = index;
    job.last  = last;
    job.v     = v;
    job.op    = cfc_pkg::OP_DEGEN;
    if (!sl.quad) begin
      if (new1 && new2) job.op = cfc_pkg::OP_TRI;
    end else if (new1 && new2 && new3) begin
      job.op = cfc_pkg::OP_QUAD;
    end else if ((new1 && new2) || (new1 && new3) || (new2 && new3)) begin
      // three distinct: drop the repeat, keep a triangle
      job.op = cfc_pkg::OP_TRI;
      if (e01) begin
        job.v[1] = v[2];
        job.v[2] = v[3];
      end else if (e02 || e12) begin
        job.v[2] = v[3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fcnt <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      fcnt <= '0;
    end else if (push) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        fcnt <= fcnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind     <= cells.cell_kind;
      index    <= cells.cell_index & cfc_pkg::SRC_MASK;
      verts[0] <= cells.vert_a;
      verts[1] <= cells.vert_b;
      verts[2] <= cells.vert_c;
      verts[3] <= cells.vert_d;
      verts[4] <= cells.vert_e;
      verts[5] <= cells.vert_f;
      verts[6] <= cells.vert_g;
      verts[7] <= cells.vert_h;
    end
  end

  `ASSERT_CLK(a_fcnt_range, busy |-> (fcnt < cfc_pkg::facet_count(kind)), "facet counter overran")
  `ASSERT_CLK(a_accept_on_last, (accept && busy) |-> (push && last), "cell taken mid-walk")
  `ASSERT_CLK(a_idle_after_last, (push && last && !accept) |=> !busy, "walk did not end")

endmodule

// ===== rtl/cfc_queue.sv =====
// Short register queue of facet jobs between front and back ends.
// Depends on cfc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  cfc_pkg::facet_job_t push_job,
  output logic                pop_valid,
  input  logic                pop_ready,
  output cfc_pkg::facet_job_t pop_job
);

  cfc_pkg::facet_job_t              entries [cfc_pkg::QUEUE_DEPTH];
  logic [cfc_pkg::Q_PTR_W-1:0]      wr_ptr;
  logic [cfc_pkg::Q_PTR_W-1:0]      rd_ptr;
  logic [cfc_pkg::Q_CNT_W-1:0]      count;
  logic                             do_push, do_pop;

  assign push_ready = (count != cfc_pkg::Q_CNT_W'(cfc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [cfc_pkg::Q_PTR_W-1:0] bump(input logic [cfc_pkg::Q_PTR_W-1:0] p);
    logic [cfc_pkg::Q_PTR_W-1:0] n;
    if (p == cfc_pkg::Q_PTR_W'(cfc_pkg::QUEUE_DEPTH - 1)) n = '0;
    else n = p + cfc_pkg::Q_PTR_W'(1);
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop) count <= count + cfc_pkg::Q_CNT_W'(1);
      else if (do_pop && !do_push) count <= count - cfc_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_job;
  end

  `ASSERT_CLK(a_count_bound, count <= cfc_pkg::Q_CNT_W'(cfc_pkg::QUEUE_DEPTH), "queue overfilled")
  `ASSERT_CLK(a_count_up, (do_push && !do_pop) |=> (count == $past(count) + cfc_pkg::Q_CNT_W'(1)), "push lost")

endmodule

// ===== rtl/cfc_back.sv =====
// Back end: puts each facet job in canonical order into the output register.
// Depends on cfc_pkg and cfc_if.
module cfc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  cfc_pkg::facet_job_t job,
  cfc_face_if.source          facets
);

  localparam logic [cfc_pkg::FACE_W-1:0] NEG1 = {cfc_pkg::FACE_W{1'b1}};

  logic                             out_valid;
  logic [cfc_pkg::VERT_W-1:0]       s0, s1, s2, tmp;
  logic                             tflip;
  logic [1:0]                       lo;
  logic [3:0][cfc_pkg::VERT_W-1:0]  r;
  logic [cfc_pkg::VERT_W-1:0]       rtmp;
  logic                             qflip;
  logic [3:0][cfc_pkg::FACE_W-1:0]  fv;
  logic                             flip_n, degen_n;
  logic                             take;

  assign job_ready    = !out_valid || facets.ready;
  assign take         = job_valid && job_ready;
  assign facets.valid = out_valid;

  // triangle: three compare-swaps, each swap flips orientation
  always_comb begin
    s0 = job.v[0];
    s1 = job.v[1];
    s2 = job.v[2];
    tmp = '0;
    tflip = 1'b0;
    if (s1 < s0) begin
      tmp = s0; s0 = s1; s1 = tmp; tflip = !tflip;
    end
    if (s2 < s0) begin
      tmp = s0; s0 = s2; s2 = tmp; tflip = !tflip;
    end
    if (s2 < s1) begin
      tmp = s1; s1 = s2; s2 = tmp; tflip = !tflip;
    end
  end

  // quad: rotate smallest to front, then order second and fourth
  always_comb begin
    lo = 2'd0;
    if (job.v[1] < job.v[lo]) lo = 2'd1;
    if (job.v[2] < job.v[lo]) lo = 2'd2;
    if (job.v[3] < job.v[lo]) lo = 2'd3;
    for (int i = 0; i < 4; i++) begin
      r[i] = job.v[lo + 2'(i)];
    end
    rtmp  = '0;
    qflip = 1'b0;
    if (r[3] < r[1]) begin
      rtmp = r[1]; r[1] = r[3]; r[3] = rtmp; qflip = 1'b1;
    end
  end

  always_comb begin
    fv      = {4{NEG1}};
    flip_n  = 1'b0;
    degen_n = 1'b1;
    case (job.op)
      cfc_pkg::OP_TRI: begin
        fv[0]   = {1'b0, s0};
        fv[1]   = {1'b0, s1};
        fv[2]   = {1'b0, s2};
        flip_n  = tflip;
        degen_n = 1'b0;
      end
      cfc_pkg::OP_QUAD: begin
        for (int i = 0; i < 4; i++) fv[i] = {1'b0, r[i]};
        flip_n  = qflip;
        degen_n = 1'b0;
      end
      default: begin
        fv      = {4{NEG1}};
        flip_n  = 1'b0;
        degen_n = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (job_ready) begin
      out_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      facets.face_v0      <= fv[0];
      facets.face_v1      <= fv[1];
      facets.face_v2      <= fv[2];
      facets.face_v3      <= fv[3];
      facets.source_kind  <= job.kind;
      facets.facet_number <= job.fnum;
      facets.source_index <= job.index;
      facets.flipped      <= flip_n;
      facets.degenerate   <= degen_n;
      facets.last_facet   <= job.last;
    end
  end

endmodule
